FILE: rtl/core/tmac_pkg.sv
package tmac_pkg;

	// Boxcar length and the widths that follow from it
	localparam int WINDOW = 10;
	localparam int CLOG_W = $clog2(WINDOW);
	localparam int SUM_W  = 17 + CLOG_W;   // signed running sum
	localparam int MAG_W  = 16 + CLOG_W;   // magnitude of the sum

	// Reciprocal of WINDOW, scaled by 2^MAG_W; low by at most one in the quotient
	localparam logic [MAG_W-1:0] RECIP_M = MAG_W'((64'd1 << MAG_W) / WINDOW);

	localparam int SAMP_W = 16;
	localparam int DIFF_W = 17;
	localparam int PROD_W = 34;
	localparam int CAL_W  = 24;
	localparam int FRAC_SH = 10;           // Q.14 down to Q.4

	// Pipeline depth, input register to output register
	localparam int NSTG = 7;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z  = 3'd5;

	localparam logic [15:0] SCALE_ONE = 16'd16384;

	typedef struct packed {
		logic signed [15:0] word_first;
		logic signed [15:0] word_second;
		logic signed [15:0] word_third;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] avg_x;
		logic signed [15:0] avg_y;
		logic signed [15:0] avg_z;
		logic signed [23:0] cal_x;
		logic signed [23:0] cal_y;
		logic signed [23:0] cal_z;
		logic signed [15:0] min_x;
		logic signed [15:0] min_y;
		logic signed [15:0] min_z;
		logic signed [15:0] max_x;
		logic signed [15:0] max_y;
		logic signed [15:0] max_z;
	} out_word_t;

	// Per-lane result
	typedef struct packed {
		logic signed [15:0]      avg;
		logic signed [CAL_W-1:0] cal;
		logic signed [15:0]      min;
		logic signed [15:0]      max;
	} lane_res_t;

	// Pipeline control shared by all lanes
	typedef struct packed {
		logic acc;   // word taken on the input
		logic adv;   // whole pipeline moves
		logic upd;   // a valid average enters the extremes stage
	} pipe_ctl_t;

endpackage

FILE: rtl/core/three_axis_moving_average_calibrate.sv
// Channel   Handshake            Word
// in        in_valid/in_ready    in_data: word_first, word_second, word_third
// out       out_valid/out_ready  out_data: avg, cal, min, max per axis
// cfg       cfg_en               cfg_index, cfg_data (no wait, no read-back)
//
// One word a cycle in, one a cycle out while the output word is not held;
// seven register stages lie between in_data and out_data. The depth
// is set by the reciprocal divide and the calibration multiply in each lane.
// Reset clears the windows to zero, minima to 32767, maxima to -32768,
// offsets to 0 and gains to 1.0. A held output word stalls every stage.
module three_axis_moving_average_calibrate
	import tmac_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_word_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_word_t            out_data,
	input  logic                 cfg_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	logic [15:0] off_x_q, off_y_q, off_z_q;
	logic [15:0] scl_x_q, scl_y_q, scl_z_q;
	pipe_ctl_t   ctl;
	lane_res_t   res_x, res_y, res_z;
	logic signed [15:0] samp_y;

	// Calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= '0;
			off_y_q <= '0;
			off_z_q <= '0;
			scl_x_q <= SCALE_ONE;
			scl_y_q <= SCALE_ONE;
			scl_z_q <= SCALE_ONE;
		end else if (cfg_en) begin
			unique case (cfg_index)
				CFG_OFFSET_X: off_x_q <= cfg_data;
				CFG_OFFSET_Y: off_y_q <= cfg_data;
				CFG_OFFSET_Z: off_z_q <= cfg_data;
				CFG_SCALE_X:  scl_x_q <= cfg_data;
				CFG_SCALE_Y:  scl_y_q <= cfg_data;
				CFG_SCALE_Z:  scl_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tmac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	// Axis remap; y wraps when the first word is most negative
	assign samp_y = $signed(~in_data.word_first + 16'd1);

	tmac_lane u_lane_x (
		.clk (clk), .arst_n (arst_n), .ctl (ctl),
		.sample (in_data.word_third), .offset (off_x_q), .scale (scl_x_q),
		.res (res_x)
	);

	tmac_lane u_lane_y (
		.clk (clk), .arst_n (arst_n), .ctl (ctl),
		.sample (samp_y), .offset (off_y_q), .scale (scl_y_q),
		.res (res_y)
	);

	tmac_lane u_lane_z (
		.clk (clk), .arst_n (arst_n), .ctl (ctl),
		.sample (in_data.word_second), .offset (off_z_q), .scale (scl_z_q),
		.res (res_z)
	);

	// Merge the lanes into the output word
	assign out_data.avg_x = res_x.avg;
	assign out_data.avg_y = res_y.avg;
	assign out_data.avg_z = res_z.avg;
	assign out_data.cal_x = res_x.cal;
	assign out_data.cal_y = res_y.cal;
	assign out_data.cal_z = res_z.cal;
	assign out_data.min_x = res_x.min;
	assign out_data.min_y = res_y.min;
	assign out_data.min_z = res_z.min;
	assign out_data.max_x = res_x.max;
	assign out_data.max_y = res_y.max;
	assign out_data.max_z = res_z.max;

endmodule

FILE: rtl/core/tmac_ctrl.sv
module tmac_ctrl
	import tmac_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output pipe_ctl_t ctl
);

	logic [NSTG-1:0] v_q;
	logic            adv;

	// Pipeline moves unless the output word is held
	assign adv       = !v_q[NSTG-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = v_q[NSTG-1];

	assign ctl.acc = in_valid && adv;
	assign ctl.adv = adv;
	assign ctl.upd = adv && v_q[4];

	// Valid bits follow the words down the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[NSTG-2:0], in_valid};
		end
	end

endmodule

FILE: rtl/core/tmac_lane.sv
module tmac_lane
	import tmac_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  pipe_ctl_t          ctl,
	input  logic signed [15:0] sample,
	input  logic [15:0]        offset,
	input  logic [15:0]        scale,
	output lane_res_t          res
);

	logic signed [SAMP_W-1:0] win_q [WINDOW];
	logic signed [SUM_W-1:0]  sum_q;

	logic [MAG_W-1:0]   mag_s2;
	logic               neg_s2;
	logic [2*MAG_W-1:0] prodm_s3;
	logic [MAG_W-1:0]   mag_s3;
	logic               neg_s3;
	logic [15:0]        q_s4;
	logic               neg_s4;
	logic signed [15:0] avg_s5;
	logic signed [15:0] avg_s6;
	logic signed [DIFF_W-1:0] diff_s6;
	logic signed [15:0] min_s6;
	logic signed [15:0] max_s6;
	logic signed [16:0] scale_s6;
	logic signed [15:0] avg_s7;
	logic signed [15:0] min_s7;
	logic signed [15:0] max_s7;
	logic signed [PROD_W-1:0] prod_s7;
	logic signed [15:0] min_q;
	logic signed [15:0] max_q;

	logic [15:0]       q0;
	logic [MAG_W-1:0]  rem;
	logic signed [15:0] min_nx;
	logic signed [15:0] max_nx;

	// Window shift line and running sum (stage 1)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				win_q[i] <= '0;
			end
			sum_q <= '0;
		end else if (ctl.acc) begin
			for (int i = 0; i < WINDOW - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WINDOW-1] <= sample;
			sum_q <= sum_q + SUM_W'(sample) - SUM_W'(win_q[0]);
		end
	end

	// Quotient estimate and one-step correction
	assign q0  = prodm_s3[MAG_W +: 16];
	assign rem = mag_s3 - MAG_W'(q0 * WINDOW);

	// Running extremes including the current average
	assign min_nx = (avg_s5 < min_q) ? avg_s5 : min_q;
	assign max_nx = (avg_s5 > max_q) ? avg_s5 : max_q;

	// Divide, extremes and calibration stages
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			// stage 2: magnitude of the sum
			neg_s2 <= sum_q[SUM_W-1];
			mag_s2 <= sum_q[SUM_W-1] ? MAG_W'(-sum_q) : MAG_W'(sum_q);
			// stage 3: reciprocal multiply
			prodm_s3 <= mag_s2 * RECIP_M;
			mag_s3   <= mag_s2;
			neg_s3   <= neg_s2;
			// stage 4: corrected magnitude of the quotient
			q_s4   <= q0 + 16'(rem >= MAG_W'(WINDOW));
			neg_s4 <= neg_s3;
			// stage 5: signed average, truncated toward zero
			avg_s5 <= $signed(neg_s4 ? (~q_s4 + 16'd1) : q_s4);
			// stage 6: extremes and offset removal
			avg_s6   <= avg_s5;
			min_s6   <= min_nx;
			max_s6   <= max_nx;
			diff_s6  <= DIFF_W'(avg_s5) - DIFF_W'($signed(offset));
			scale_s6 <= $signed({1'b0, scale});
			// stage 7: gain, output register
			avg_s7  <= avg_s6;
			min_s7  <= min_s6;
			max_s7  <= max_s6;
			prod_s7 <= diff_s6 * scale_s6;
		end
	end

	// Extremes state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= 16'sh7fff;
			max_q <= -16'sh8000;
		end else if (ctl.upd) begin
			min_q <= min_nx;
			max_q <= max_nx;
		end
	end

	// Arithmetic shift floors to four fractional bits
	assign res.avg = avg_s7;
	assign res.cal = prod_s7[FRAC_SH +: CAL_W];
	assign res.min = min_s7;
	assign res.max = max_s7;

endmodule

FILE: tb/sv/three_axis_moving_average_calibrate_tb.sv
`timescale 1ns / 1ps

module three_axis_moving_average_calibrate_tb;
	import tmac_pkg::*;

	// Indexes past the register list; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
	localparam int NUM_AXES     = 3;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_WORDS  = 203;
	localparam int DRAIN_CYCLES = 4000;
	localparam int TIMEOUT_NS   = 2_000_000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_word_t             in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_word_t            out_data;
	logic                 cfg_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = '0;

	// Filter state as the testbench sees it
	logic signed [15:0] win_hist [NUM_AXES][WINDOW];
	logic signed [15:0] avg_min [NUM_AXES];
	logic signed [15:0] avg_max [NUM_AXES];
	logic signed [15:0] cal_offset [NUM_AXES];
	logic [15:0]        cal_gain [NUM_AXES];

	out_word_t filtered_q[$];
	out_word_t want;
	int        level [NUM_AXES];
	int        errors = 0;
	int        words_in = 0;
	int        words_out = 0;
	int        reg_writes = 0;
	int        stall_left = 0;
	bit        in_gaps = 1'b0;
	bit        out_stalls = 1'b0;

	three_axis_moving_average_calibrate u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return $urandom_range(1, 3);
		end else if (r < 95) begin
			return $urandom_range(4, 8);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [15:0] pick_corner();
		case ($urandom_range(0, 3))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return 16'sd0;
			default: return -16'sd1;
		endcase
	endfunction

	// Level plus small noise, clamped, with some raw and corner samples mixed in
	function automatic logic signed [15:0] pick_sample(int lvl);
		int v;
		case ($urandom_range(0, 9))
			0, 1: return 16'($urandom);
			2: return pick_corner();
			default: begin
				v = lvl + $urandom_range(0, 64) - 32;
				if (v > 32767) begin
					v = 32767;
				end else if (v < -32768) begin
					v = -32768;
				end
				return v[15:0];
			end
		endcase
	endfunction

	function automatic logic [15:0] pick_reg_value();
		case ($urandom_range(0, 6))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			4: return SCALE_ONE;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic in_word_t make_word(int first, int second, int third);
		in_word_t w;
		w.word_first  = first[15:0];
		w.word_second = second[15:0];
		w.word_third  = third[15:0];
		return w;
	endfunction

	// Remap, boxcar average, track extremes and calibrate for one input word
	function automatic out_word_t boxcar_step(in_word_t w);
		logic signed [15:0] samp [NUM_AXES];
		logic signed [15:0] avg [NUM_AXES];
		logic signed [23:0] cal [NUM_AXES];
		int                 sum;
		longint             prod;
		out_word_t          r;
		samp[0] = w.word_third;
		samp[1] = -w.word_first;   // most negative word wraps onto itself
		samp[2] = w.word_second;
		for (int a = 0; a < NUM_AXES; a++) begin
			for (int i = 0; i < WINDOW - 1; i++) begin
				win_hist[a][i] = win_hist[a][i+1];
			end
			win_hist[a][WINDOW-1] = samp[a];
			sum = 0;
			for (int i = 0; i < WINDOW; i++) begin
				sum += win_hist[a][i];
			end
			avg[a] = 16'(sum / WINDOW);
			if (avg[a] < avg_min[a]) begin
				avg_min[a] = avg[a];
			end
			if (avg[a] > avg_max[a]) begin
				avg_max[a] = avg[a];
			end
			// arithmetic shift floors the Q.14 product to Q.4
			prod = (longint'(avg[a]) - longint'(cal_offset[a])) * longint'(cal_gain[a]);
			cal[a] = 24'(prod >>> FRAC_SH);
		end
		r.avg_x = avg[0];
		r.avg_y = avg[1];
		r.avg_z = avg[2];
		r.cal_x = cal[0];
		r.cal_y = cal[1];
		r.cal_z = cal[2];
		r.min_x = avg_min[0];
		r.min_y = avg_min[1];
		r.min_z = avg_min[2];
		r.max_x = avg_max[0];
		r.max_y = avg_max[1];
		r.max_z = avg_max[2];
		return r;
	endfunction

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	// Receiver: random stalls when enabled
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if (out_stalls && $urandom_range(0, 3) == 0) begin
				stall_left <= pick_gap();
			end
		end
	end

	// Compare each output word against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (filtered_q.size() == 0) begin
				$error("output word with no prediction waiting");
				errors++;
			end else begin
				want = filtered_q.pop_front();
				check_field("avg_x", want.avg_x, out_data.avg_x);
				check_field("avg_y", want.avg_y, out_data.avg_y);
				check_field("avg_z", want.avg_z, out_data.avg_z);
				check_field("cal_x", want.cal_x, out_data.cal_x);
				check_field("cal_y", want.cal_y, out_data.cal_y);
				check_field("cal_z", want.cal_z, out_data.cal_z);
				check_field("min_x", want.min_x, out_data.min_x);
				check_field("min_y", want.min_y, out_data.min_y);
				check_field("min_z", want.min_z, out_data.min_z);
				check_field("max_x", want.max_x, out_data.max_x);
				check_field("max_y", want.max_y, out_data.max_y);
				check_field("max_z", want.max_z, out_data.max_z);
			end
			words_out++;
		end
	end

	// Offer one word, wait for the handshake, then record the prediction
	task automatic send_word(in_word_t w);
		int gap;
		gap = (in_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		filtered_q.push_back(boxcar_step(w));
		words_in++;
	endtask

	// Stop sending and let every outstanding word come back
	task automatic settle();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (filtered_q.size() != 0 && waited < DRAIN_CYCLES) begin
			@(posedge clk);
			waited++;
		end
		if (filtered_q.size() != 0) begin
			$error("%0d predicted words never came out", filtered_q.size());
			errors++;
			filtered_q.delete();
		end
		repeat (NSTG + 2) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_OFFSET_X: cal_offset[0] = val;
			CFG_OFFSET_Y: cal_offset[1] = val;
			CFG_OFFSET_Z: cal_offset[2] = val;
			CFG_SCALE_X:  cal_gain[0] = val;
			CFG_SCALE_Y:  cal_gain[1] = val;
			CFG_SCALE_Z:  cal_gain[2] = val;
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic end_writes();
		cfg_en <= 1'b0;
	endtask

	task automatic set_all_regs(logic [15:0] offset, logic [15:0] gain);
		write_reg(CFG_OFFSET_X, offset);
		write_reg(CFG_OFFSET_Y, offset);
		write_reg(CFG_OFFSET_Z, offset);
		write_reg(CFG_SCALE_X, gain);
		write_reg(CFG_SCALE_Y, gain);
		write_reg(CFG_SCALE_Z, gain);
		end_writes();
	endtask

	// Windows still filling with zeros, default offsets and gains
	task automatic test_partial_window();
		send_word(make_word(-32768, 32767, -1));
		send_word(make_word(32767, -32768, 0));
		send_word(make_word(1234, -4321, 32767));
		settle();
	endtask

	// Writes past the last register must leave calibration untouched
	task automatic test_unused_index();
		write_reg(CFG_UNUSED_LO, 16'hA5A5);
		write_reg(CFG_UNUSED_HI, 16'h0000);
		end_writes();
		send_word(make_word(-100, 200, -300));
		send_word(make_word(0, -1, 1));
		settle();
	endtask

	// Averages driven to both rails with widest offset and largest gain
	task automatic test_full_scale_extremes();
		set_all_regs(16'h8000, 16'hFFFF);
		repeat (WINDOW) send_word(make_word(-32767, 32767, 32767));
		settle();
		set_all_regs(16'h7FFF, 16'hFFFF);
		// negating the most negative word stays at the bottom rail
		repeat (WINDOW) send_word(make_word(-32768, -32768, -32768));
		settle();
	endtask

	// Random phases: fresh registers and idling mode each time
	task automatic test_random_traffic();
		for (int p = 0; p < RAND_PHASES; p++) begin
			write_reg(CFG_OFFSET_X, pick_reg_value());
			write_reg(CFG_OFFSET_Y, pick_reg_value());
			write_reg(CFG_OFFSET_Z, pick_reg_value());
			write_reg(CFG_SCALE_X, pick_reg_value());
			write_reg(CFG_SCALE_Y, pick_reg_value());
			write_reg(CFG_SCALE_Z, pick_reg_value());
			if ($urandom_range(0, 1) == 0) begin
				write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
					16'($urandom));
			end
			end_writes();
			in_gaps = (p != 0) && ($urandom_range(0, 3) != 0);
			out_stalls = (p != 0) && ($urandom_range(0, 3) != 0);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n % 30 == 0) begin
					for (int a = 0; a < NUM_AXES; a++) begin
						level[a] = ($urandom_range(0, 2) == 0) ? int'(pick_corner())
							: int'($signed(16'($urandom)));
					end
				end
				send_word(make_word(pick_sample(-level[1]), pick_sample(level[2]),
					pick_sample(level[0])));
				// hold off now and then until the pipeline is empty
				if ($urandom_range(0, 149) == 0) begin
					settle();
				end
			end
			settle();
		end
	endtask

	initial begin
		for (int a = 0; a < NUM_AXES; a++) begin
			for (int i = 0; i < WINDOW; i++) begin
				win_hist[a][i] = '0;
			end
			avg_min[a] = 16'sd32767;
			avg_max[a] = -16'sd32768;
			cal_offset[a] = '0;
			cal_gain[a] = SCALE_ONE;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_partial_window();
		test_unused_index();
		test_full_scale_extremes();
		test_random_traffic();

		repeat (NSTG * 2) @(posedge clk);
		$display("Sent %0d words and checked %0d results over %0d register writes",
			words_in, words_out, reg_writes);
		$display("Covered filling windows, negation wrap, rail averages, unused indexes, stalls");
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Hard stop if the handshakes hang
	initial begin
		#(TIMEOUT_NS);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: three_axis_moving_average_calibrate.f
rtl/core/tmac_pkg.sv
rtl/core/tmac_ctrl.sv
rtl/core/tmac_lane.sv
rtl/core/three_axis_moving_average_calibrate.sv
tb/sv/three_axis_moving_average_calibrate_tb.sv
